/* src/fenwick_prefix_sum_engine_defines.svh */
// Assertion macros shared by the Fenwick prefix-sum engine RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef FENWICK_PREFIX_SUM_ENGINE_DEFINES_SVH
`define FENWICK_PREFIX_SUM_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fps assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define FPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fps assertion failed");

`endif

/* src/fps_pkg.sv */
// Shared constants and types of the Fenwick prefix-sum engine.
// No dependencies; used by the interfaces, the RAM user and the top level.
`default_nettype none

package fps_pkg;

    // Tree size (power of two) and derived widths
    localparam int SIZE     = 1024;
    localparam int DEPTH    = SIZE + 1;
    localparam int NODE_W   = $clog2(DEPTH);

    // Payload widths fixed by the channel format
    localparam int ACTION_W = 2;
    localparam int POS_W    = 11;
    localparam int DATA_W   = 32;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

/* src/fps_if.sv */
// Request and response channel interfaces of the Fenwick prefix-sum engine.
// Depends on fps_pkg for payload widths.
`default_nettype none

interface fps_req_if;
    logic                          valid;
    logic                          ready;
    logic [fps_pkg::ACTION_W-1:0]  action;
    logic [fps_pkg::POS_W-1:0]     position;
    logic signed [fps_pkg::DATA_W-1:0] operand;

    modport source (output valid, output action, output position, output operand,
                    input ready);
    modport sink   (input valid, input action, input position, input operand,
                    output ready);
endinterface

interface fps_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [fps_pkg::DATA_W-1:0] sum;
    logic [fps_pkg::POS_W-1:0]         found_index;

    modport source (output valid, output sum, output found_index, input ready);
    modport sink   (input valid, input sum, input found_index, output ready);
endinterface

`default_nettype wire

/* src/fps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fps_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/fenwick_prefix_sum_engine.sv */
// Fenwick prefix-sum engine: binary indexed tree walked by a small sequencer.
// Depends on fps_pkg, fps_if.sv, fps_ram and fenwick_prefix_sum_engine_defines.svh.
//
// Usage
//   req (sink): action, position, operand; a request is taken when valid and
//   ready are high at a clock edge. ready is high only while the sequencer idles,
//   so a new request is taken only after the previous one has finished.
//   rsp (source): sum, found_index; one response for each query or search,
//   none for an add, an out-of-range add or an unknown action.
// Walk after acceptance (N = log2(SIZE) + 1 tree levels, 11 at SIZE = 1024)
//   add    : one node read per cycle, write-back overlapped.
//   query  : one node per set bit of the count; an empty count goes straight
//            to the response hand-off.
//   search : a read then a compare for each level.
//   The walk speed is set by the single RAM read port and the shared adder.
// Reset
//   After rst_n rises, a clearing pass writes zero to all SIZE + 1 RAM entries,
//   one per cycle; ready stays low meanwhile.
// Stalls
//   The response sits in an output register; a new request is taken while it
//   waits. A finished result then holds in the sequencer until rsp is free.
`default_nettype none
`include "fenwick_prefix_sum_engine_defines.svh"

module fenwick_prefix_sum_engine (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fps_req_if.sink    req,
    fps_rsp_if.source  rsp
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_ADD   = 7'b0000100,
        S_QUERY = 7'b0001000,
        S_SRD   = 7'b0010000,
        S_SCMP  = 7'b0100000,
        S_PUSH  = 7'b1000000
    } state_t;

    state_t                         state_reg, state_next;
    fps_pkg::node_t                 clr_reg, clr_next;
    fps_pkg::node_t                 node_reg, node_next;
    logic                           node_live_reg, node_live_next;
    fps_pkg::node_t                 wr_node_reg, wr_node_next;
    logic                           data_live_reg, data_live_next;
    fps_pkg::data_t                 opnd_reg, opnd_next;
    fps_pkg::data_t                 acc_reg, acc_next;
    fps_pkg::node_t                 i_reg, i_next;
    fps_pkg::node_t                 k_reg, k_next;
    logic                           first_reg, first_next;
    fps_pkg::data_t                 res_sum_reg, res_sum_next;
    logic [fps_pkg::POS_W-1:0]      res_idx_reg, res_idx_next;
    logic                           out_valid_reg, out_valid_next;
    fps_pkg::data_t                 out_sum_reg, out_sum_next;
    logic [fps_pkg::POS_W-1:0]      out_idx_reg, out_idx_next;

    logic                           ram_we;
    fps_pkg::node_t                 ram_waddr;
    fps_pkg::data_t                 ram_wdata;
    fps_pkg::node_t                 ram_raddr;
    fps_pkg::data_t                 ram_rdata;

    logic [fps_pkg::NODE_W:0]       node_ext;
    logic [fps_pkg::NODE_W:0]       node_low;
    logic [fps_pkg::NODE_W:0]       node_up;
    fps_pkg::node_t                 node_down;
    fps_pkg::node_t                 srch_addr;
    fps_pkg::node_t                 k_half;
    fps_pkg::node_t                 qry_start;
    fps_pkg::data_t                 addend;
    fps_pkg::data_t                 add_sum;
    logic                           at_least;
    logic                           push_free;

    logic                           chk_walk_live;
    logic                           chk_node_ok;
    logic                           chk_srch_busy;
    logic                           chk_push_stall;
    logic                           chk_quiet;

    localparam fps_pkg::node_t SIZE_NODE = fps_pkg::NODE_W'(fps_pkg::SIZE);

    // Tree store
    fps_ram #(
        .WIDTH (fps_pkg::DATA_W),
        .DEPTH (fps_pkg::DEPTH)
    ) u_tree_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Node index arithmetic: climb for add, strip lowest bit for query, step and halve for search
    assign node_ext  = {1'b0, node_reg};
    assign node_low  = node_ext & (~node_ext + 1'b1);
    assign node_up   = node_ext + node_low;
    assign node_down = node_reg & (node_reg - 1'b1);
    assign srch_addr = i_reg + k_reg;
    assign k_half    = k_reg >> 1;
    assign qry_start = (32'(req.position) > 32'(fps_pkg::SIZE))
                     ? SIZE_NODE
                     : fps_pkg::NODE_W'(req.position);

    // Shared adder and signed threshold compare
    assign addend   = (state_reg == S_ADD) ? opnd_reg : acc_reg;
    assign add_sum  = ram_rdata + addend;
    assign at_least = $signed(add_sum) >= $signed(opnd_reg);

    // RAM port steering
    always_comb
    begin
        ram_raddr = (state_reg == S_SRD) ? srch_addr : node_reg;
        ram_we    = 1'b0;
        ram_waddr = wr_node_reg;
        ram_wdata = add_sum;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_ADD:
            begin
                ram_we = data_live_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign push_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        node_live_next = node_live_reg;
        wr_node_next   = wr_node_reg;
        data_live_next = data_live_reg;
        opnd_next      = opnd_reg;
        acc_next       = acc_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        first_next     = first_reg;
        res_sum_next   = res_sum_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_sum_next   = out_sum_reg;
        out_idx_next   = out_idx_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SIZE_NODE)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    opnd_next      = req.operand;
                    acc_next       = '0;
                    data_live_next = 1'b0;
                    case (req.action)
                        fps_pkg::ACT_ADD:
                        begin
                            if (32'(req.position) < 32'(fps_pkg::SIZE))
                            begin
                                node_next      = fps_pkg::NODE_W'(req.position) + 1'b1;
                                node_live_next = 1'b1;
                                state_next     = S_ADD;
                            end
                        end
                        fps_pkg::ACT_QUERY:
                        begin
                            res_idx_next = '0;
                            if (qry_start == '0)
                            begin
                                res_sum_next = '0;
                                state_next   = S_PUSH;
                            end
                            else
                            begin
                                node_next      = qry_start;
                                node_live_next = 1'b1;
                                state_next     = S_QUERY;
                            end
                        end
                        fps_pkg::ACT_SEARCH:
                        begin
                            i_next     = '0;
                            k_next     = SIZE_NODE;
                            first_next = 1'b1;
                            state_next = S_SRD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Read node, write back the previous one in the same cycle
            S_ADD:
            begin
                wr_node_next   = node_reg;
                data_live_next = node_live_reg;
                node_next      = node_up[fps_pkg::NODE_W-1:0];
                node_live_next = node_live_reg
                               && (node_up <= (fps_pkg::NODE_W+1)'(fps_pkg::SIZE));
                if (!node_live_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            // Read node, accumulate the previous read
            S_QUERY:
            begin
                if (data_live_reg)
                begin
                    acc_next = add_sum;
                end
                data_live_next = node_live_reg;
                node_next      = node_down;
                node_live_next = node_live_reg && (node_down != '0);
                if (!node_live_reg)
                begin
                    res_sum_next = add_sum;
                    state_next   = S_PUSH;
                end
            end

            S_SRD:
            begin
                state_next = S_SCMP;
            end

            // Binary-lifting step on the registered read data
            S_SCMP:
            begin
                first_next   = 1'b0;
                k_next       = k_half;
                res_sum_next = '0;
                if (first_reg && !at_least)
                begin
                    res_idx_next = fps_pkg::POS_W'(SIZE_NODE);
                    state_next   = S_PUSH;
                end
                else
                begin
                    if (!at_least)
                    begin
                        i_next   = srch_addr;
                        acc_next = add_sum;
                    end
                    if (k_half == '0)
                    begin
                        res_idx_next = fps_pkg::POS_W'(at_least ? i_reg : srch_addr);
                        state_next   = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
            end

            // Hand the result to the output register once it is free
            S_PUSH:
            begin
                if (push_free)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = res_sum_reg;
                    out_idx_next   = res_idx_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            node_live_reg  <= 1'b0;
            data_live_reg  <= 1'b0;
            first_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            node_live_reg  <= node_live_next;
            data_live_reg  <= data_live_next;
            first_reg      <= first_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        wr_node_reg <= wr_node_next;
        opnd_reg    <= opnd_next;
        acc_reg     <= acc_next;
        i_reg       <= i_next;
        k_reg       <= k_next;
        res_sum_reg <= res_sum_next;
        res_idx_reg <= res_idx_next;
        out_sum_reg <= out_sum_next;
        out_idx_reg <= out_idx_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.sum         = out_sum_reg;
    assign rsp.found_index = out_idx_reg;

    // Check terms
    assign chk_walk_live  = ((state_reg == S_ADD) || (state_reg == S_QUERY)) && node_live_reg;
    assign chk_node_ok    = (node_reg != '0) && (32'(node_reg) <= 32'(fps_pkg::SIZE));
    assign chk_srch_busy  = (state_reg == S_SRD) || (state_reg == S_SCMP);
    assign chk_push_stall = (state_reg == S_PUSH) && out_valid_reg && !rsp.ready;
    assign chk_quiet      = !out_valid_reg && !req.ready;

    // Checks
    `FPS_ASSERT_NOW(a_node_in_tree, clk, rst_n, chk_walk_live, chk_node_ok)
    `FPS_ASSERT_NOW(a_search_step_onehot, clk, rst_n, chk_srch_busy, $onehot(k_reg))
    `FPS_ASSERT_NEXT(a_push_holds, clk, rst_n, chk_push_stall, state_reg == S_PUSH)
    `FPS_ASSERT_NOW(a_quiet_while_clearing, clk, rst_n, state_reg == S_CLEAR, chk_quiet)

endmodule

`default_nettype wire

/* bench/fenwick_prefix_sum_engine_tb.sv */
// Self-checking bench for the Fenwick prefix-sum engine: directed and random requests,
// checked against a behavioural tree model held in a small scoreboard class.
// Depends on fps_pkg, fps_if.sv and the fenwick_prefix_sum_engine RTL.
`default_nettype none

module fenwick_prefix_sum_engine_tb;

    // Action code that the engine ignores
    localparam logic [fps_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 510;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [fps_pkg::DATA_W-1:0] sum;
        logic [fps_pkg::POS_W-1:0]  found_index;
    } tree_result_t;

    // Behavioural tree plus the queue of responses still owed by the engine
    class fenwick_scoreboard;
        bit [fps_pkg::DATA_W-1:0] node_sum [0:fps_pkg::SIZE];
        tree_result_t             owed [$];
        int                       mismatches;

        function void add_delta(int unsigned slot, bit [fps_pkg::DATA_W-1:0] delta);
            int unsigned i;
            i = slot + 1;
            while (i <= fps_pkg::SIZE)
            begin
                node_sum[i] += delta;
                i += i & (~i + 1);
            end
        endfunction

        function bit [fps_pkg::DATA_W-1:0] prefix_total(int unsigned count);
            bit [fps_pkg::DATA_W-1:0] acc;
            int unsigned              c;
            acc = '0;
            c   = (count > fps_pkg::SIZE) ? fps_pkg::SIZE : count;
            while (c != 0)
            begin
                acc += node_sum[c];
                c &= c - 1;
            end
            return acc;
        endfunction

        // Top-down binary-lifting walk, signed threshold test
        function int unsigned locate(bit [fps_pkg::DATA_W-1:0] threshold);
            int unsigned              i;
            int unsigned              k;
            bit [fps_pkg::DATA_W-1:0] acc;
            bit [fps_pkg::DATA_W-1:0] t;
            i   = 0;
            k   = fps_pkg::SIZE;
            acc = '0;
            if ($signed(node_sum[fps_pkg::SIZE]) < $signed(threshold))
                return fps_pkg::SIZE;
            k = k >> 1;
            while (k != 0)
            begin
                t = acc + node_sum[i + k];
                if ($signed(t) < $signed(threshold))
                begin
                    i   += k;
                    acc  = t;
                end
                k = k >> 1;
            end
            return i;
        endfunction

        // Called for every accepted request
        function void note_request(logic [fps_pkg::ACTION_W-1:0] action,
                                   logic [fps_pkg::POS_W-1:0] position,
                                   logic [fps_pkg::DATA_W-1:0] operand);
            tree_result_t r;
            r = '0;
            case (action)
                fps_pkg::ACT_ADD:
                begin
                    if (position < fps_pkg::SIZE)
                        add_delta(position, operand);
                end
                fps_pkg::ACT_QUERY:
                begin
                    r.sum = prefix_total(position);
                    owed.push_back(r);
                end
                fps_pkg::ACT_SEARCH:
                begin
                    r.found_index = fps_pkg::POS_W'(locate(operand));
                    owed.push_back(r);
                end
                default: ;
            endcase
        endfunction

        // Called for every accepted response
        function void check_response(logic [fps_pkg::DATA_W-1:0] sum,
                                     logic [fps_pkg::POS_W-1:0] found_index);
            tree_result_t r;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected response: sum %0d index %0d", $signed(sum),
                             found_index);
                return;
            end
            r = owed.pop_front();
            if (sum !== r.sum || found_index !== r.found_index)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("response mismatch: sum exp %0d got %0d, index exp %0d got %0d",
                             $signed(r.sum), $signed(sum), r.found_index, found_index);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function bit failed();
            return (mismatches != 0) || (owed.size() != 0);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    fps_req_if req_ch ();
    fps_rsp_if rsp_ch ();

    fenwick_prefix_sum_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    fenwick_scoreboard sb = new;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Response side: ready decided at the falling edge, long hold-off when asked
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Response check at the rising edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.sum, rsp_ch.found_index);
        end
    end

    // Offer one request; entered and left just after a falling edge
    task send_request(logic [fps_pkg::ACTION_W-1:0] action,
                      logic [fps_pkg::POS_W-1:0] position,
                      logic [fps_pkg::DATA_W-1:0] operand);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= action;
        req_ch.position <= position;
        req_ch.operand  <= operand;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(action, position, operand);
        @(negedge clk);
    endtask

    // One random request; counted tells whether the engine acts on it
    task random_request(output bit counted);
        int unsigned                pick;
        int unsigned                sel;
        logic [fps_pkg::POS_W-1:0]  pos;
        logic [fps_pkg::DATA_W-1:0] opnd;
        pick = $urandom_range(99);
        sel  = $urandom_range(9);
        if (pick < 40)
        begin
            pos = ($urandom_range(19) == 0)
                ? fps_pkg::POS_W'($urandom_range(2047, fps_pkg::SIZE))
                : fps_pkg::POS_W'($urandom_range(fps_pkg::SIZE - 1));
            if (sel < 6)
                opnd = $urandom_range(1000);
            else if (sel < 8)
                opnd = 32'd0 - $urandom_range(1000);
            else
                opnd = $urandom;
            counted = (pos < fps_pkg::SIZE);
            send_request(fps_pkg::ACT_ADD, pos, opnd);
        end
        else if (pick < 65)
        begin
            pos     = (sel == 0) ? fps_pkg::POS_W'($urandom_range(2047))
                                 : fps_pkg::POS_W'($urandom_range(fps_pkg::SIZE));
            counted = 1'b1;
            send_request(fps_pkg::ACT_QUERY, pos, $urandom);
        end
        else if (pick < 95)
        begin
            // thresholds mostly sit close to a real prefix sum
            if (sel < 7)
                opnd = sb.prefix_total($urandom_range(fps_pkg::SIZE, 1))
                     + $urandom_range(4) - 32'd2;
            else
                opnd = $urandom;
            counted = 1'b1;
            send_request(fps_pkg::ACT_SEARCH, fps_pkg::POS_W'($urandom_range(2047)), opnd);
        end
        else
        begin
            counted = 1'b0;
            send_request(ACT_NONE, fps_pkg::POS_W'($urandom_range(2047)), $urandom);
        end
    endtask

    // Drop valid, then change the idle mix at a rising edge
    task set_phase(int send_pct, int recv_pct, int hold);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        hold_left     = hold;
        @(negedge clk);
    endtask

    task random_phase();
        int done;
        bit counted;
        done = 0;
        while (done < PHASE_ITEMS)
        begin
            random_request(counted);
            if (counted)
                done++;
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = fps_pkg::ACT_ADD;
        req_ch.position = '0;
        req_ch.operand  = '0;
        send_idle_pct   = 29;
        recv_idle_pct   = 51;
        hold_left       = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty tree, extremes, ignored requests, wrap-around, non-monotone sums
        send_request(fps_pkg::ACT_QUERY,  11'd0,    32'd0);
        send_request(fps_pkg::ACT_SEARCH, 11'd0,    32'd1);
        send_request(fps_pkg::ACT_SEARCH, 11'd0,    32'd0);
        send_request(fps_pkg::ACT_SEARCH, 11'd0,    32'h8000_0000);
        send_request(fps_pkg::ACT_ADD,    11'd0,    32'h7fff_ffff);
        send_request(fps_pkg::ACT_ADD,    11'd1023, 32'h8000_0000);
        send_request(fps_pkg::ACT_ADD,    11'd1024, 32'd5);
        send_request(fps_pkg::ACT_ADD,    11'd2047, 32'hffff_ffff);
        send_request(ACT_NONE,            11'd2047, 32'hffff_ffff);
        send_request(fps_pkg::ACT_QUERY,  11'd1,    32'd0);
        send_request(fps_pkg::ACT_QUERY,  11'd1023, 32'd0);
        send_request(fps_pkg::ACT_QUERY,  11'd1024, 32'd0);
        send_request(fps_pkg::ACT_QUERY,  11'd2047, 32'd0);
        send_request(fps_pkg::ACT_SEARCH, 11'd0,    32'h7fff_ffff);
        send_request(fps_pkg::ACT_ADD,    11'd512,  32'hffff_fff9);
        send_request(fps_pkg::ACT_ADD,    11'd300,  32'd100);
        send_request(fps_pkg::ACT_ADD,    11'd700,  32'd50);
        send_request(fps_pkg::ACT_SEARCH, 11'd0,    32'd100);
        send_request(fps_pkg::ACT_SEARCH, 11'd0,    32'd1);
        send_request(fps_pkg::ACT_QUERY,  11'd512,  32'd0);
        send_request(fps_pkg::ACT_QUERY,  11'd701,  32'd0);
        send_request(fps_pkg::ACT_SEARCH, 11'd0,    32'hffff_fffd);
        send_request(fps_pkg::ACT_ADD,    11'd5,    32'h5555_5555);
        send_request(fps_pkg::ACT_ADD,    11'd6,    32'haaaa_aaaa);
        send_request(fps_pkg::ACT_QUERY,  11'd7,    32'd0);

        // Random: three idle mixes, long receiver hold-off at the start of the second
        random_phase();
        set_phase(51, 29, HOLD_CYCLES);
        random_phase();
        set_phase(0, 0, 0);
        random_phase();
        req_ch.valid <= 1'b0;

        // Drain
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (!sb.failed())
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+src
src/fps_pkg.sv
src/fps_if.sv
src/fps_ram.sv
src/fenwick_prefix_sum_engine.sv
bench/fenwick_prefix_sum_engine_tb.sv
